>>> src/sexpr_token_scanner_core_defines.svh
// Assertion macros shared by the scanner RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SEXPR_TOKEN_SCANNER_CORE_DEFINES_SVH
`define SEXPR_TOKEN_SCANNER_CORE_DEFINES_SVH

// Check that a condition holds at every edge outside reset
`define STS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next
`define STS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sts_pkg.sv
// Types, codes and helpers of the s-expression token scanner.
// No dependencies; imported by the register block and the top level.
package sts_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_OPEN    = 3'd0;
    localparam logic [2:0] REG_CLOSE   = 3'd1;
    localparam logic [2:0] REG_COMMENT = 3'd2;
    localparam logic [2:0] REG_QUOTE   = 3'd3;
    localparam logic [2:0] REG_ESCAPE  = 3'd4;

    // Delimiter reset values
    localparam logic [7:0] OPEN_RST    = 8'd40;
    localparam logic [7:0] CLOSE_RST   = 8'd41;
    localparam logic [7:0] COMMENT_RST = 8'd59;
    localparam logic [7:0] QUOTE_RST   = 8'd34;
    localparam logic [7:0] ESCAPE_RST  = 8'd92;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam int         MAX_RESULTS  = 3;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_ATOM    = 4'b0010,
        MODE_STRING  = 4'b0100,
        MODE_COMMENT = 4'b1000
    } scan_mode_t;

    typedef enum logic [2:0] {
        KIND_OPEN         = 3'd0,
        KIND_CLOSE        = 3'd1,
        KIND_ATOM         = 3'd2,
        KIND_STRING       = 3'd3,
        KIND_END          = 3'd4,
        KIND_UNTERMINATED = 3'd5
    } kind_t;

    typedef struct packed {
        logic [7:0] open_char;
        logic [7:0] close_char;
        logic [7:0] comment_char;
        logic [7:0] quote_char;
        logic [7:0] escape_char;
    } cfg_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] end_offset;
        logic        run_last;
    } out_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start_off;
        logic [15:0] end_off;
    } entry_t;

    // Results caused by one byte, oldest in entry zero
    typedef struct packed {
        entry_t [MAX_RESULTS-1:0] ent;
        logic [1:0]               cnt;
    } group_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b inside {[8'h09:8'h0D]});
    endfunction

    // Append one result to a group
    function automatic group_t push(input group_t g, input kind_t k,
                                    input logic [15:0] s, input logic [15:0] e);
        group_t r;
        r = g;
        r.ent[g.cnt].kind      = k;
        r.ent[g.cnt].start_off = s;
        r.ent[g.cnt].end_off   = e;
        r.cnt                  = g.cnt + 2'd1;
        return r;
    endfunction

endpackage

>>> src/sts_cfg_regs.sv
// APB-style register block holding the delimiter bytes of the scanner.
// Depends on sts_pkg for register indexes, reset values and cfg_t.
module sts_cfg_regs
    import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Write the addressed delimiter; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_char    <= OPEN_RST;
            cfg_reg.close_char   <= CLOSE_RST;
            cfg_reg.comment_char <= COMMENT_RST;
            cfg_reg.quote_char   <= QUOTE_RST;
            cfg_reg.escape_char  <= ESCAPE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_OPEN:    cfg_reg.open_char    <= pwdata[7:0];
                REG_CLOSE:   cfg_reg.close_char   <= pwdata[7:0];
                REG_COMMENT: cfg_reg.comment_char <= pwdata[7:0];
                REG_QUOTE:   cfg_reg.quote_char   <= pwdata[7:0];
                REG_ESCAPE:  cfg_reg.escape_char  <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    // Read back the addressed delimiter
    always_comb
    begin
        case (reg_idx)
            REG_OPEN:    prdata = {24'd0, cfg_reg.open_char};
            REG_CLOSE:   prdata = {24'd0, cfg_reg.close_char};
            REG_COMMENT: prdata = {24'd0, cfg_reg.comment_char};
            REG_QUOTE:   prdata = {24'd0, cfg_reg.quote_char};
            REG_ESCAPE:  prdata = {24'd0, cfg_reg.escape_char};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

>>> src/sexpr_token_scanner_core.sv
// Top level of the s-expression token scanner: byte classifier and result drain.
// Depends on sts_pkg, sts_cfg_regs and sexpr_token_scanner_core_defines.svh.
//
//  channel   direction  handshake                 payload
//  byte      in         byte_valid / byte_ready   in_t  (text_byte, end_of_text)
//  token     out        token_valid / token_ready out_t (kind, offsets, run_last)
//  config    in         psel / penable / pready   pwdata, paddr, prdata
//
// A byte is classified in the cycle it is accepted; its zero to three results go
// to a two-deep group buffer that drains one result per cycle while token_ready is
// high. Bytes with at most one result then flow at one per cycle; a byte with n
// results holds the token port until all drain, and the two group registers set
// the slack. byte_ready falls only while both group registers are full, however
// long token_ready stays low. Reset clears the scan state and empties the buffer.
`include "sexpr_token_scanner_core_defines.svh"

module sexpr_token_scanner_core
    import sts_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  in_t         byte_data,
    output logic        token_valid,
    input  logic        token_ready,
    output out_t        token_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] POS_ONE = OFFSET_BITS'(1);

    cfg_t cfg;

    scan_mode_t             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] tstart_reg, tstart_next;
    logic                   esc_reg, esc_next;

    group_t     a_grp_reg, a_grp_next;
    logic       a_valid_reg, a_valid_next;
    logic [1:0] a_idx_reg, a_idx_next;
    group_t     b_grp_reg, b_grp_next;
    logic       b_valid_reg, b_valid_next;

    group_t                 grp;
    logic                   accept;
    logic                   new_grp;
    logic                   tok_fire;
    logic                   a_done;
    logic                   cls;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [7:0]             b;
    logic                   is_open, is_close, is_comment, is_quote, is_esc, is_ws;
    entry_t                 cur;

    function automatic logic [15:0] lo16(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+15:0] w;
        w = {16'd0, v};
        return w[15:0];
    endfunction

    sts_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Classify the byte against the delimiters
    assign b          = byte_data.text_byte;
    assign is_open    = (b == cfg.open_char);
    assign is_close   = (b == cfg.close_char);
    assign is_comment = (b == cfg.comment_char);
    assign is_quote   = (b == cfg.quote_char);
    assign is_esc     = (b == cfg.escape_char);
    assign is_ws      = is_space(b);
    assign pos_inc    = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_ONE;

    // Work out the results and the next scan state of the offered byte
    always_comb
    begin
        grp         = '0;
        mode_next   = mode_reg;
        tstart_next = tstart_reg;
        esc_next    = esc_reg;
        pos_next    = pos_inc;
        cls         = 1'b0;

        case (mode_reg)
            MODE_IDLE:
            begin
                cls = 1'b1;
            end
            MODE_ATOM:
            begin
                if (is_open || is_close || is_comment || is_ws)
                begin
                    grp       = push(grp, KIND_ATOM, lo16(tstart_reg), lo16(pos_reg));
                    mode_next = MODE_IDLE;
                    cls       = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (is_quote && !esc_reg)
                begin
                    grp       = push(grp, KIND_STRING, lo16(tstart_reg), lo16(pos_reg));
                    mode_next = MODE_IDLE;
                    esc_next  = 1'b0;
                end
                else
                begin
                    esc_next = is_esc;
                end
            end
            MODE_COMMENT:
            begin
                if (b == NEWLINE_BYTE)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // Start a token from the idle position
        if (cls)
        begin
            if (is_open)
            begin
                grp = push(grp, KIND_OPEN, lo16(pos_reg), lo16(pos_inc));
            end
            else if (is_close)
            begin
                grp = push(grp, KIND_CLOSE, lo16(pos_reg), lo16(pos_inc));
            end
            else if (is_comment)
            begin
                mode_next = MODE_COMMENT;
            end
            else if (is_quote)
            begin
                mode_next   = MODE_STRING;
                tstart_next = pos_inc;
                esc_next    = is_esc;
            end
            else if (!is_ws)
            begin
                mode_next   = MODE_ATOM;
                tstart_next = pos_reg;
            end
        end

        // Flush at the last byte and rewind for the next document
        if (byte_data.end_of_text)
        begin
            if (mode_next == MODE_ATOM)
            begin
                grp = push(grp, KIND_ATOM, lo16(tstart_next), lo16(pos_inc));
            end
            if (mode_next == MODE_STRING)
            begin
                grp = push(grp, KIND_UNTERMINATED, lo16(tstart_next), lo16(pos_inc));
            end
            else
            begin
                grp = push(grp, KIND_END, lo16(pos_inc), lo16(pos_inc));
            end
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            tstart_next = '0;
            esc_next    = 1'b0;
        end
    end

    // Handshakes
    assign byte_ready  = !b_valid_reg;
    assign accept      = byte_valid & byte_ready;
    assign new_grp     = accept & (grp.cnt != 2'd0);
    assign token_valid = a_valid_reg;
    assign tok_fire    = a_valid_reg & token_ready;
    assign a_done      = tok_fire & (a_idx_reg == a_grp_reg.cnt - 2'd1);

    // Present the current result of the head group
    assign cur                     = a_grp_reg.ent[a_idx_reg];
    assign token_data.token_kind   = cur.kind;
    assign token_data.start_offset = cur.start_off;
    assign token_data.end_offset   = cur.end_off;
    assign token_data.run_last     = (a_idx_reg == a_grp_reg.cnt - 2'd1);

    // Advance the head group, refill from the skid group or from the new byte
    always_comb
    begin
        a_grp_next   = a_grp_reg;
        a_valid_next = a_valid_reg;
        a_idx_next   = a_idx_reg;
        b_grp_next   = b_grp_reg;
        b_valid_next = b_valid_reg;

        if (a_done)
        begin
            a_idx_next = 2'd0;
            if (b_valid_reg)
            begin
                a_grp_next   = b_grp_reg;
                b_valid_next = 1'b0;
            end
            else if (new_grp)
            begin
                a_grp_next = grp;
            end
            else
            begin
                a_valid_next = 1'b0;
            end
        end
        else
        begin
            if (tok_fire)
            begin
                a_idx_next = a_idx_reg + 2'd1;
            end
            if (new_grp)
            begin
                if (a_valid_reg)
                begin
                    b_grp_next   = grp;
                    b_valid_next = 1'b1;
                end
                else
                begin
                    a_grp_next   = grp;
                    a_valid_next = 1'b1;
                    a_idx_next   = 2'd0;
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            pos_reg     <= '0;
            tstart_reg  <= '0;
            esc_reg     <= 1'b0;
            a_valid_reg <= 1'b0;
            a_idx_reg   <= 2'd0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                tstart_reg <= tstart_next;
                esc_reg    <= esc_next;
            end
            a_valid_reg <= a_valid_next;
            a_idx_reg   <= a_idx_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        a_grp_reg <= a_grp_next;
        b_grp_reg <= b_grp_next;
    end

    `STS_ASSERT_ALWAYS(a_skid_needs_head, clk, rst_n, !b_valid_reg || a_valid_reg, "skid group without head group")
    `STS_ASSERT_ALWAYS(a_head_not_empty, clk, rst_n, !a_valid_reg || (a_grp_reg.cnt != 2'd0), "empty group buffered")
    `STS_ASSERT_ALWAYS(a_idx_in_range, clk, rst_n, !a_valid_reg || (a_idx_reg < a_grp_reg.cnt), "result index past group")
    `STS_ASSERT_NEXT(a_rewind_at_end, clk, rst_n, accept && byte_data.end_of_text, (pos_reg == '0) && (mode_reg == MODE_IDLE), "no rewind after last byte")

endmodule
